FILE: design/crse_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and codes for the catmull-rom spline evaluator
// no dependencies; imported by every module of the block

package crse_pkg;

   // field widths fixed by the interface
   localparam int COORD_BITS     = 16;
   localparam int GRAD_BITS      = COORD_BITS + 4;
   localparam int FRAC_BITS      = 16;
   localparam int INDEX_BITS     = 8;
   localparam int CFG_BITS       = 9;
   localparam int STATUS_BITS    = 2;
   localparam int MAX_POINTS_DEF = 256;

   // internal datapath widths
   localparam int CNT_W  = 14;                        // holds any table size up to 16383
   localparam int WGT_W  = FRAC_BITS + 6;             // blend weights, Q4.16 plus headroom
   localparam int PROD_W = COORD_BITS + WGT_W;        // one point times one weight
   localparam int SUM_W  = PROD_W + 2;                // sum of four products
   localparam int BANKS  = 4;
   localparam int BANK_SEL_W = 2;
   localparam int ROW_W  = INDEX_BITS + 1 - BANK_SEL_W;

   // opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   // status codes
   localparam logic [STATUS_BITS-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_BAD_SEG = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_BAD_IDX = 2'd2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } point_type;

   // control point write into the banked store
   typedef struct packed {
      logic                  en;
      logic [INDEX_BITS-1:0] index;
      point_type             pt;
   } wr_req_type;

   // four-point read of one segment
   typedef struct packed {
      logic                  en;
      logic [INDEX_BITS-1:0] seg;
   } rd_req_type;

   // per-stage load enables of one blend lane
   typedef struct packed {
      logic mul;
      logic pair;
      logic fin;
   } lane_en_type;

   // per-transaction tag that travels alongside the datapath
   typedef struct packed {
      logic                   emit;
      logic [STATUS_BITS-1:0] status;
   } tag_type;

endpackage

FILE: design/catmull_rom_spline_eval.sv
`timescale 1ns / 1ps
// uniform catmull-rom spline evaluator: top level with pipeline control,
// weight generation and config register; uses crse_pkg, crse_point_store,
// crse_blend_lane
//
//   channel  ports                      direction  moves
//   req      req_valid / req_ready      in         point write or evaluate transaction
//   rsp      rsp_valid / rsp_ready      out        position, gradient and status
//   csr      csr_valid / csr_ready      in         points_in_use write
//
// one transaction per cycle while rsp_ready keeps the last stage moving; rsp_valid is the
// valid bit of the last pipeline stage register
// in-range writes land in the banked table at acceptance; four banks with one read port each
// supply the four segment points in one access
// each full stage holds while the stage after it is stalled; no clearing pass
// reset is synchronous, holds req_ready and csr_ready low, clears the valid bits
// and sets points_in_use to 4

module catmull_rom_spline_eval #(
   parameter int MAX_POINTS = crse_pkg::MAX_POINTS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // request channel
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_opcode,
   input  logic [crse_pkg::INDEX_BITS-1:0]          req_point_index,
   input  logic signed [crse_pkg::COORD_BITS-1:0]   req_point_x,
   input  logic signed [crse_pkg::COORD_BITS-1:0]   req_point_y,
   input  logic [crse_pkg::INDEX_BITS-1:0]          req_segment_index,
   input  logic [crse_pkg::FRAC_BITS-1:0]           req_fraction,
   // response channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [crse_pkg::COORD_BITS-1:0]   rsp_pos_x,
   output logic signed [crse_pkg::COORD_BITS-1:0]   rsp_pos_y,
   output logic signed [crse_pkg::GRAD_BITS-1:0]    rsp_grad_x,
   output logic signed [crse_pkg::GRAD_BITS-1:0]    rsp_grad_y,
   output logic [crse_pkg::STATUS_BITS-1:0]         rsp_status,
   // config channel
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [crse_pkg::CFG_BITS-1:0]            csr_wdata
);
   import crse_pkg::*;

   localparam int STAGES = 6;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);
   localparam logic signed [WGT_W-1:0] ONE = WGT_W'(64'sd1 <<< FRAC_BITS);

   // pipeline control
   logic [STAGES:1]   valid_ff;
   logic [STAGES:1]   valid_in;
   logic [STAGES:1]   rdy;
   tag_type           tag_ff [STAGES:1];
   tag_type           tag_in;

   // config register
   logic [CFG_BITS-1:0] points_in_use_ff;
   logic [CNT_W-1:0]    used_cnt;

   // datapath registers
   logic [FRAC_BITS-1:0]       f1_ff, f2_ff;
   logic [FRAC_BITS-1:0]       t2_1_ff, t2_2_ff;
   logic [FRAC_BITS-1:0]       t3_2_ff;
   logic [2*FRAC_BITS-1:0]     sq_prod;
   logic [2*FRAC_BITS-1:0]     cube_prod;
   point_type [3:0]            store_pts;
   point_type [3:0]            pts2_ff, pts3_ff;
   logic [3:0][WGT_W-1:0]      w3_ff, d3_ff;
   logic signed [WGT_W-1:0]    fs, t2s, t3s;

   wr_req_type                 wr_req;
   rd_req_type                 rd_req;
   lane_en_type                lane_en;
   logic [3:0][COORD_BITS-1:0] lane_x, lane_y;
   logic signed [COORD_BITS-1:0] pos_x, pos_y;
   logic signed [GRAD_BITS-1:0]  grad_x, grad_y;

   logic accept;
   logic wr_ok;
   logic seg_ok;

   // config register write
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         points_in_use_ff <= CFG_BITS'(4);
      end else if (csr_valid && csr_ready) begin
         points_in_use_ff <= csr_wdata;
      end
   end

   assign used_cnt = (CNT_W'(points_in_use_ff) > MAX_CNT) ? MAX_CNT : CNT_W'(points_in_use_ff);

   // ready chain: a stage loads when empty or when its successor moves
   always_comb begin
      rdy[STAGES] = !valid_ff[STAGES] || rsp_ready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k + 1];
      end
   end

   always_comb begin
      valid_in[1] = rdy[1] ? req_valid : valid_ff[1];
      for (int k = 2; k <= STAGES; k++) begin
         valid_in[k] = rdy[k] ? valid_ff[k - 1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = rdy[1] && !reset;
   assign accept    = req_valid && req_ready;

   // range checks at acceptance
   assign wr_ok  = CNT_W'(req_point_index) < used_cnt;
   assign seg_ok = (CNT_W'(req_segment_index) + CNT_W'(3)) < used_cnt;

   always_comb begin
      tag_in.emit   = 1'b0;
      tag_in.status = STAT_OK;
      if (req_opcode == OP_EVAL) begin
         tag_in.emit   = seg_ok;
         tag_in.status = seg_ok ? STAT_OK : STAT_BAD_SEG;
      end else if (!wr_ok) begin
         tag_in.status = STAT_BAD_IDX;
      end
   end

   // tag travels with the transaction
   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         tag_ff[1] <= tag_in;
      end
      for (int k = 2; k <= STAGES; k++) begin
         if (rdy[k]) begin
            tag_ff[k] <= tag_ff[k - 1];
         end
      end
   end

   // point table
   assign wr_req.en    = accept && (req_opcode == OP_WRITE) && wr_ok;
   assign wr_req.index = req_point_index;
   assign wr_req.pt.x  = req_point_x;
   assign wr_req.pt.y  = req_point_y;
   assign rd_req.en    = rdy[1];
   assign rd_req.seg   = req_segment_index;

   crse_point_store #(
      .MAX_POINTS (MAX_POINTS)
   ) u_store (
      .clock  (clock),
      .wr_req (wr_req),
      .rd_req (rd_req),
      .rd_pts (store_pts)
   );

   // stage 1: square of the fraction
   assign sq_prod = req_fraction * req_fraction;

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         f1_ff   <= req_fraction;
         t2_1_ff <= sq_prod[2*FRAC_BITS-1:FRAC_BITS];
      end
   end

   // stage 2: cube of the fraction, capture the segment points
   assign cube_prod = t2_1_ff * f1_ff;

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         f2_ff   <= f1_ff;
         t2_2_ff <= t2_1_ff;
         t3_2_ff <= cube_prod[2*FRAC_BITS-1:FRAC_BITS];
         pts2_ff <= store_pts;
      end
   end

   // stage 3: position and gradient weights
   assign fs  = $signed(WGT_W'(f2_ff));
   assign t2s = $signed(WGT_W'(t2_2_ff));
   assign t3s = $signed(WGT_W'(t3_2_ff));

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         pts3_ff  <= pts2_ff;
         w3_ff[0] <= -t3s + WGT_W'(2) * t2s - fs;
         w3_ff[1] <= WGT_W'(3) * t3s - WGT_W'(5) * t2s + WGT_W'(2) * ONE;
         w3_ff[2] <= -(WGT_W'(3) * t3s) + WGT_W'(4) * t2s + fs;
         w3_ff[3] <= t3s - t2s;
         d3_ff[0] <= -(WGT_W'(3) * t2s) + WGT_W'(4) * fs - ONE;
         d3_ff[1] <= WGT_W'(9) * t2s - WGT_W'(10) * fs;
         d3_ff[2] <= -(WGT_W'(9) * t2s) + WGT_W'(8) * fs + ONE;
         d3_ff[3] <= WGT_W'(3) * t2s - WGT_W'(2) * fs;
      end
   end

   // stages 4 to 6: blend lanes
   assign lane_en.mul  = rdy[4];
   assign lane_en.pair = rdy[5];
   assign lane_en.fin  = rdy[6];

   for (genvar i = 0; i < 4; i++) begin : g_coord
      assign lane_x[i] = pts3_ff[i].x;
      assign lane_y[i] = pts3_ff[i].y;
   end

   crse_blend_lane #(.OUT_W(COORD_BITS)) u_pos_x (
      .clock (clock), .en (lane_en), .coords (lane_x), .weights (w3_ff), .result (pos_x)
   );

   crse_blend_lane #(.OUT_W(COORD_BITS)) u_pos_y (
      .clock (clock), .en (lane_en), .coords (lane_y), .weights (w3_ff), .result (pos_y)
   );

   crse_blend_lane #(.OUT_W(GRAD_BITS)) u_grad_x (
      .clock (clock), .en (lane_en), .coords (lane_x), .weights (d3_ff), .result (grad_x)
   );

   crse_blend_lane #(.OUT_W(GRAD_BITS)) u_grad_y (
      .clock (clock), .en (lane_en), .coords (lane_y), .weights (d3_ff), .result (grad_y)
   );

   // response: fields are zero for writes and rejected transactions
   assign rsp_valid  = valid_ff[STAGES];
   assign rsp_status = tag_ff[STAGES].status;
   assign rsp_pos_x  = tag_ff[STAGES].emit ? pos_x  : '0;
   assign rsp_pos_y  = tag_ff[STAGES].emit ? pos_y  : '0;
   assign rsp_grad_x = tag_ff[STAGES].emit ? grad_x : '0;
   assign rsp_grad_y = tag_ff[STAGES].emit ? grad_y : '0;

endmodule

FILE: design/crse_point_store.sv
`timescale 1ns / 1ps
// control point table split into four banks by index modulo four
// so one segment reads its four points in one access; uses crse_pkg

module crse_point_store #(
   parameter int MAX_POINTS = crse_pkg::MAX_POINTS_DEF
) (
   input  logic                            clock,
   input  crse_pkg::wr_req_type            wr_req,
   input  crse_pkg::rd_req_type            rd_req,
   output crse_pkg::point_type [3:0]       rd_pts
);
   import crse_pkg::*;

   localparam int BANK_DEPTH = (MAX_POINTS + BANKS - 1) / BANKS;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   point_type             rd_data_ff [BANKS];
   logic [BANK_SEL_W-1:0] seg_lo_ff;

   // remember which bank holds the first point of the segment
   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         seg_lo_ff <= rd_req.seg[BANK_SEL_W-1:0];
      end
   end

   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      point_type             mem [BANK_DEPTH];
      logic [BANK_SEL_W-1:0] off;
      logic [INDEX_BITS:0]   sum;
      logic [BANK_AW-1:0]    rd_addr;
      logic [BANK_AW-1:0]    wr_addr;
      logic                  wr_hit;

      // row of this bank that holds one of points seg .. seg+3
      assign off     = BANK_SEL_W'(b) - rd_req.seg[BANK_SEL_W-1:0];
      assign sum     = {1'b0, rd_req.seg} + (INDEX_BITS + 1)'(off);
      assign rd_addr = BANK_AW'(sum[INDEX_BITS:BANK_SEL_W]);
      assign wr_addr = BANK_AW'(wr_req.index[INDEX_BITS-1:BANK_SEL_W]);
      assign wr_hit  = wr_req.en && (wr_req.index[BANK_SEL_W-1:0] == BANK_SEL_W'(b));

      always_ff @(posedge clock) begin
         if (wr_hit) begin
            mem[wr_addr] <= wr_req.pt;
         end
         if (rd_req.en) begin
            rd_data_ff[b] <= mem[rd_addr];
         end
      end
   end

   // rotate bank outputs into point order
   for (genvar k = 0; k < BANKS; k++) begin : g_rot
      assign rd_pts[k] = rd_data_ff[seg_lo_ff + BANK_SEL_W'(k)];
   end

endmodule

FILE: design/crse_blend_lane.sv
`timescale 1ns / 1ps
// one blend lane: four point-by-weight products, a pair-sum stage and
// a final sum with rounding and saturation; uses crse_pkg

module crse_blend_lane #(
   parameter int OUT_W = crse_pkg::COORD_BITS
) (
   input  logic                                      clock,
   input  crse_pkg::lane_en_type                     en,
   input  logic [3:0][crse_pkg::COORD_BITS-1:0]      coords,
   input  logic [3:0][crse_pkg::WGT_W-1:0]           weights,
   output logic signed [OUT_W-1:0]                   result
);
   import crse_pkg::*;

   localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(64'sd1 <<< FRAC_BITS);
   localparam logic signed [SUM_W-1:0] HI    = SUM_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] LO    = -HI - SUM_W'(64'sd1);

   logic signed [PROD_W-1:0] prod_ff [4];
   logic signed [SUM_W-1:0]  pair_ff [2];
   logic signed [SUM_W-1:0]  acc;
   logic signed [SUM_W-1:0]  scaled;
   logic signed [SUM_W-1:0]  clamped;
   logic signed [OUT_W-1:0]  result_ff;

   // products
   always_ff @(posedge clock) begin
      if (en.mul) begin
         for (int i = 0; i < 4; i++) begin
            prod_ff[i] <= $signed(coords[i]) * $signed(weights[i]);
         end
      end
   end

   // pair sums
   always_ff @(posedge clock) begin
      if (en.pair) begin
         pair_ff[0] <= SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]);
         pair_ff[1] <= SUM_W'(prod_ff[2]) + SUM_W'(prod_ff[3]);
      end
   end

   // halve and drop the FRAC_BITS fraction bits with round half up, then clamp to the field range
   always_comb begin
      acc    = pair_ff[0] + pair_ff[1] + ROUND;
      scaled = acc >>> (FRAC_BITS + 1);
      if (scaled > HI) begin
         clamped = HI;
      end else if (scaled < LO) begin
         clamped = LO;
      end else begin
         clamped = scaled;
      end
   end

   always_ff @(posedge clock) begin
      if (en.fin) begin
         result_ff <= OUT_W'(clamped);
      end
   end

   assign result = result_ff;

endmodule
